### design/asb_pkg.sv
// Shared constants and types for the array bubble sorter.
// Used by array_bubble_sort. Has no dependencies of its own.
`default_nettype none

package asb_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

endpackage

`default_nettype wire

### design/array_bubble_sort.sv
// Array sorter: loads signed words, bubble-sorts them in a RAM, streams them out ascending.
// Depends on asb_pkg (sizes, types) and asb_ram (element store).
//
// Usage:
//  - Input channel (item_valid / item_stall, fields value, last): one element per
//    word. While loading, item_stall is low and a word is taken every cycle.
//    The word with last = 1 closes the array; item_stall then stays high until
//    the last sorted word has been loaded into the output register.
//  - Elements past MAX_ITEMS are discarded; the final output word shows dropped = 1.
//  - Sorting: passes over the RAM with one comparator and a carry register holding
//    the element being bubbled up. Passes end at index n-1 down to 1; each runs
//    PASS_START, PASS_FIRST, PASS_RUN per index up to its end, then PASS_END (none for n = 1).
//    The single RAM read port and the comparator set the pace of a pass.
//  - Output channel (res_valid / res_stall, fields value_res, last_res, dropped):
//    n words, ascending, last_res on the final one. Each word is read in EMIT_RD and
//    loaded in EMIT_LD; the output register holds its word while res_stall is high,
//    and the sequencer waits for it.
//  - The output register parts the two sides: a new array is accepted while the
//    final word of the previous one still waits to be taken.
//  - Reset (arst_n low, asynchronous): empty array, no output word pending.
//    The RAM needs no clearing; only entries written for the current array are used.
`default_nettype none

module array_bubble_sort (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire asb_pkg::data_t value,
	input  wire logic          last,
	output logic               res_valid,
	input  wire logic          res_stall,
	output asb_pkg::data_t     value_res,
	output logic               last_res,
	output logic               dropped
);

	import asb_pkg::*;

	typedef enum logic [2:0] {
		LOAD,
		PASS_START,
		PASS_FIRST,
		PASS_RUN,
		PASS_END,
		EMIT_RD,
		EMIT_LD
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	logic   ovf_q;
	idx_t   idx_q;
	idx_t   pass_end_q;
	idx_t   emit_q;
	data_t  carry_q;
	logic   res_valid_q;
	data_t  value_res_q;
	logic   last_res_q;
	logic   dropped_q;

	logic   wr_en;
	idx_t   wr_addr;
	data_t  wr_data;
	idx_t   rd_addr;
	data_t  rd_data;

	logic   accept;
	logic   full;
	cnt_t   cnt_nxt;
	logic   gt;
	logic   out_free;
	logic   fin;

	assign item_stall = (state_q != LOAD);
	assign accept     = item_valid && !item_stall;
	assign full       = (count_q == CNT_W'(MAX_ITEMS));
	assign cnt_nxt    = full ? count_q : count_q + CNT_W'(1);
	assign gt         = carry_q > rd_data;   // signed compare, equal keeps order
	assign out_free   = !res_valid_q || !res_stall;
	assign fin        = (CNT_W'(emit_q) + CNT_W'(1)) == count_q;

	// store write: load, bubble step (smaller goes down), end of pass (carry lands)
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = value;
		unique case (state_q)
			LOAD: begin
				wr_en = accept && !full;
			end
			PASS_RUN: begin
				wr_en   = 1'b1;
				wr_addr = idx_q - IDX_W'(1);
				wr_data = gt ? rd_data : carry_q;
			end
			PASS_END: begin
				wr_en   = 1'b1;
				wr_addr = pass_end_q;
				wr_data = carry_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			PASS_FIRST: rd_addr = IDX_W'(1);
			PASS_RUN:   rd_addr = idx_q + IDX_W'(1);
			EMIT_RD,
			EMIT_LD:    rd_addr = emit_q;
			default:    rd_addr = '0;
		endcase
	end

	asb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			pass_end_q  <= '0;
			emit_q      <= '0;
			carry_q     <= '0;
			res_valid_q <= 1'b0;
			value_res_q <= '0;
			last_res_q  <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			// word taken; EMIT_LD sets the valid flag itself
			if (res_valid_q && !res_stall && state_q != EMIT_LD) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				LOAD: begin
					if (accept) begin
						count_q <= cnt_nxt;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							pass_end_q <= idx_t'(cnt_nxt - CNT_W'(1));
							emit_q     <= '0;
							state_q    <= (cnt_nxt >= CNT_W'(2)) ? PASS_START : EMIT_RD;
						end
					end
				end
				PASS_START: begin
					state_q <= PASS_FIRST;
				end
				PASS_FIRST: begin
					carry_q <= rd_data;
					idx_q   <= IDX_W'(1);
					state_q <= PASS_RUN;
				end
				PASS_RUN: begin
					// carry keeps the larger; the smaller was written one slot down
					if (!gt) begin
						carry_q <= rd_data;
					end
					if (idx_q == pass_end_q) begin
						state_q <= PASS_END;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				PASS_END: begin
					if (pass_end_q == IDX_W'(1)) begin
						emit_q  <= '0;
						state_q <= EMIT_RD;
					end else begin
						pass_end_q <= pass_end_q - IDX_W'(1);
						state_q    <= PASS_START;
					end
				end
				EMIT_RD: begin
					state_q <= EMIT_LD;
				end
				EMIT_LD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						value_res_q <= rd_data;
						last_res_q  <= fin;
						dropped_q   <= fin && ovf_q;
						if (fin) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= LOAD;
						end else begin
							emit_q  <= emit_q + IDX_W'(1);
							state_q <= EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= LOAD;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign value_res = value_res_q;
	assign last_res  = last_res_q;
	assign dropped   = dropped_q;

`ifndef ASSERT_OFF
	a_run_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PASS_RUN) |-> (idx_q != '0 && idx_q <= pass_end_q))
		else $error("bubble index outside current pass");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count above capacity");

	a_drop_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && dropped) |-> last_res)
		else $error("dropped flag on a non-final word");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && last) |=> item_stall)
		else $error("input not stalled after closing word");
`endif

endmodule

`default_nettype wire

### design/asb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone, no package needed.
`default_nettype none

module asb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### tb/array_bubble_sort_test.sv
// Self-checking testbench for array_bubble_sort: sends arrays of signed words, keeps its
// own ascending-sort prediction and checks every output word, field by field.
// Depends on asb_pkg (types, MAX_ITEMS) and the array_bubble_sort RTL.
`timescale 1ns / 100ps

module array_bubble_sort_test;
	import asb_pkg::*;

	localparam int    CYCLE_LIMIT = 600000;
	localparam int    WORD_TARGET = 410;
	localparam data_t WORD_MIN    = 32'sh8000_0000;
	localparam data_t WORD_MAX    = 32'sh7FFF_FFFF;

	// How the random part picks element values.
	typedef enum logic [1:0] {VAL_WIDE, VAL_NARROW, VAL_CORNER} val_mix_t;

	// One expected output word.
	typedef struct {
		data_t v;
		logic  fin;
		logic  drp;
	} sorted_word_t;

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	data_t value;
	logic  last;
	logic  res_valid;
	logic  res_stall;
	data_t value_res;
	logic  last_res;
	logic  dropped;

	// Predictor state: words of the array being loaded, drop flag, expected sorted stream.
	data_t        unsorted_words[$];
	bit           words_lost;
	sorted_word_t sorted_due[$];

	int mismatches;
	int words_sent;
	int cycle_count;

	// Idle controls, written by the test sequence only.
	bit tx_idle_on;
	bit rx_idle_on;
	// Long receiver hold-off request: toggling hold_ask asks for hold_len stalled cycles.
	bit hold_ask;
	int hold_len;

	array_bubble_sort u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.last       (last),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value_res  (value_res),
		.last_res   (last_res),
		.dropped    (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	function automatic data_t pick_value(val_mix_t mix);
		data_t corners [7] = '{WORD_MIN, WORD_MIN + 1, -1, 0, 1, WORD_MAX - 1, WORD_MAX};
		case (mix)
			VAL_NARROW: begin
				// small spread, so equal values are common
				return data_t'($urandom_range(0, 16)) - data_t'(8);
			end
			VAL_CORNER: begin
				return corners[$urandom_range(0, 6)];
			end
			default: begin
				return data_t'($urandom());
			end
		endcase
	endfunction

	// Predictor: store the word (or note the drop); on the closing word bubble-sort the
	// stored words and queue one expected output word per stored element.
	function automatic void absorb_word(data_t v, logic is_last);
		data_t        arr[$];
		data_t        t;
		sorted_word_t w;
		int           n;
		if (unsorted_words.size() < MAX_ITEMS)
			unsorted_words.push_back(v);
		else
			words_lost = 1'b1;
		if (!is_last)
			return;
		arr = unsorted_words;
		n = arr.size();
		for (int p = 0; p < n - 1; p++) begin
			for (int k = 0; k + 1 < n - p; k++) begin
				// strict signed compare: equal words never swap
				if (arr[k] > arr[k + 1]) begin
					t = arr[k];
					arr[k] = arr[k + 1];
					arr[k + 1] = t;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			w.v = arr[k];
			w.fin = (k == n - 1);
			w.drp = w.fin && words_lost;
			sorted_due.push_back(w);
		end
		unsorted_words.delete();
		words_lost = 1'b0;
	endfunction

	// Offer one word and wait for it to be taken. Valid is only lowered for a gap, so
	// back-to-back words keep it high with no glitch in the same step.
	task automatic send_word(input data_t v, input logic is_last);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		absorb_word(v, is_last);
		words_sent++;
	endtask

	task automatic send_array(input int n, input val_mix_t mix);
		for (int i = 0; i < n; i++)
			send_word(pick_value(mix), i == n - 1);
	endtask

	// Sender pause: drop valid and wait until every expected word has come out.
	task automatic settle();
		item_valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Single-element arrays, extremes of the value range, equal values,
	// already ascending and fully descending input.
	task automatic test_directed();
		send_word(5, 1'b1);
		send_word(WORD_MIN, 1'b1);
		send_word(WORD_MAX, 1'b0); send_word(WORD_MIN, 1'b0); send_word(0, 1'b0);
		send_word(-1, 1'b0); send_word(1, 1'b0); send_word(WORD_MAX, 1'b0);
		send_word(WORD_MIN, 1'b1);
		send_word(3, 1'b0); send_word(3, 1'b0); send_word(1, 1'b0); send_word(3, 1'b0);
		send_word(1, 1'b1);
		send_word(-2, 1'b0); send_word(-1, 1'b0); send_word(0, 1'b0); send_word(1, 1'b0);
		send_word(2, 1'b1);
		send_word(2, 1'b0); send_word(1, 1'b0); send_word(0, 1'b0); send_word(-1, 1'b0);
		send_word(-2, 1'b1);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering two arrays
	// back to back: the output register fills and the input side must stall.
	task automatic test_long_hold();
		tx_idle_on = 1'b0;
		hold_len = 300;
		hold_ask = ~hold_ask;
		send_array(12, VAL_WIDE);
		send_array(10, VAL_NARROW);
		tx_idle_on = 1'b1;
	endtask

	// Exactly full store, one word too many (the closing word is dropped), and a
	// few more past capacity.
	task automatic test_overflow();
		send_array(MAX_ITEMS, VAL_WIDE);
		send_array(MAX_ITEMS + 1, VAL_NARROW);
		send_array(MAX_ITEMS + 2 + $urandom_range(0, 4), VAL_WIDE);
	endtask

	// Random arrays, mostly short, with now and then a stretch of no idling on either side.
	task automatic test_random_arrays();
		int r;
		int n;
		while (words_sent < WORD_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				n = $urandom_range(1, 12);
			else if (r < 95)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(41, MAX_ITEMS);
			r = $urandom_range(0, 3);
			tx_idle_on = (r != 0);
			rx_idle_on = (r != 0);
			send_array(n, val_mix_t'($urandom_range(0, 2)));
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver stall driver: a requested long hold-off takes priority, otherwise random
	// stall bursts while rx_idle_on is set.
	initial begin
		int  stall_left;
		int  hold_left;
		bit  hold_ack;
		stall_left = 0;
		hold_left = 0;
		hold_ack = 1'b0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_ack) begin
				hold_ack = hold_ask;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				stall_left = pick_gap() - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Output checker: every word taken is compared with the oldest expectation.
	always @(posedge clk) begin : check_res
		sorted_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (sorted_due.size() == 0) begin
				mismatches++;
				$display("%0t: output word %0d with nothing expected", $time, value_res);
			end else begin
				want = sorted_due.pop_front();
				if (value_res !== want.v) begin
					mismatches++;
					$display("%0t: value_res mismatch, expected %0d, got %0d",
						$time, want.v, value_res);
				end
				if (last_res !== want.fin) begin
					mismatches++;
					$display("%0t: last_res mismatch, expected %0b, got %0b",
						$time, want.fin, last_res);
				end
				if (dropped !== want.drp) begin
					mismatches++;
					$display("%0t: dropped mismatch, expected %0b, got %0b",
						$time, want.drp, dropped);
				end
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL array_bubble_sort");
		$finish;
	end

	// Test sequence.
	initial begin
		mismatches = 0;
		words_sent = 0;
		words_lost = 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_ask = 1'b0;
		hold_len = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		settle();
		test_long_hold();
		settle();
		test_overflow();
		settle();
		test_random_arrays();
		settle();
		// quiet window: any stray output word shows up as a failure here
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("PASS array_bubble_sort");
		else
			$display("FAIL array_bubble_sort");
		$finish;
	end

endmodule
